### rtl/core/sgff_pkg.sv
// sgff_pkg: shared types and constants of the slot grid first-fit allocator
// used by sgff_cell and slot_grid_first_fit_allocator_unit
`default_nettype none
package sgff_pkg;

  localparam int ROWS_DEF  = 16;
  localparam int SLOTS_DEF = 16;

  localparam logic [4:0] ROWS_IN_USE_RESET = 5'd16;

  // register index, taken from paddr bit 2 (word address)
  localparam logic REG_ROWS_IN_USE = 1'b0;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam logic [1:0] ST_SINGLE = 2'd0;
  localparam logic [1:0] ST_FRAG   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_READ   = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_SINGLE,
    OP_FRAG,
    OP_READ
  } chain_op_t;

  typedef struct packed {
    logic       mode;
    logic [4:0] first_slot;
    logic [4:0] end_slot;
    logic [7:0] owner_tag;
    logic [3:0] read_row;
    logic [3:0] read_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] placed_row;
    logic [7:0] cell_owner;
  } out_item_t;

  // command token handed from cell to cell, one column per cycle
  typedef struct packed {
    logic       valid;
    chain_op_t  op;
    logic [4:0] first_slot;
    logic [4:0] end_slot;
    logic [7:0] owner_tag;
    logic [3:0] read_row;
    logic [3:0] read_slot;
    logic [7:0] cell_owner;
  } chain_cmd_t;

endpackage
`default_nettype wire

### rtl/core/sgff_cell.sv
// sgff_cell: one grid column (one time slot) holding the owner tags of all rows
// depends on sgff_pkg for the chain command type
`default_nettype none
module sgff_cell #(
  parameter int ROWS  = 16,
  parameter int COL   = 0,
  parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  sgff_pkg::chain_cmd_t      cmd_i,
  input  wire  [ROWS-1:0]           active_i,
  input  wire  [ROW_W-1:0]          sel_row_i,
  output sgff_pkg::chain_cmd_t      cmd_o,
  output logic [ROWS-1:0]           free_o
);
  import sgff_pkg::*;

  logic [7:0]  tag_r [ROWS];
  chain_cmd_t  cmd_r;
  chain_cmd_t  cmd_nxt;
  logic        in_win;
  logic        wr_en;
  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] frag_row;
  logic        rd_hit;
  logic [ROW_W-1:0] rd_idx;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      free_o[r] = (tag_r[r] == 8'd0);
    end
  end

  // lowest free row among the searched rows
  always_comb begin
    frag_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (free_o[r] && active_i[r]) begin
        frag_row = ROW_W'(r);
      end
    end
  end

  always_comb begin
    in_win = cmd_i.valid && (int'(cmd_i.first_slot) <= COL) && (COL < int'(cmd_i.end_slot));
    wr_en  = 1'b0;
    wr_row = sel_row_i;
    case (cmd_i.op)
      OP_SINGLE: wr_en = in_win;
      OP_FRAG: begin
        wr_en  = in_win;
        wr_row = frag_row;
      end
      default: wr_en = 1'b0;
    endcase
    rd_hit = cmd_i.valid && (cmd_i.op == OP_READ) && (int'(cmd_i.read_slot) == COL) &&
             (int'(cmd_i.read_row) < ROWS);
    rd_idx = ROW_W'(cmd_i.read_row);
    cmd_nxt = cmd_i;
    if (rd_hit) begin
      cmd_nxt.cell_owner = tag_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        tag_r[r] <= 8'd0;
      end
      cmd_r <= '0;
    end else begin
      if (wr_en) begin
        tag_r[wr_row] <= cmd_i.owner_tag;
      end
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_o = cmd_r;

endmodule
`default_nettype wire

### rtl/core/slot_grid_first_fit_allocator_unit.sv
// slot_grid_first_fit_allocator_unit: top level, control, occupancy check and cell chain
// depends on sgff_pkg and sgff_cell
//
// Use: items arrive on in_valid/in_stall with an in_item_t payload; one result per item
// leaves on out_valid/out_stall as an out_item_t. rows_in_use must be set over APB
// at byte address 0 while idle; the block does not enforce it. pready is always high.
// An accepted item is held in a register for the occupancy check, where the free masks of all
// columns are combined to pick the lowest fully free row or a fragmented placement, then
// its command token walks the chain of SLOTS column cells, one cell per cycle, writing
// tags or picking up the read cell on the way.
// The next item is taken only once the result of the last one has moved to the output
// register, so the block takes no new item while one is in the check, walks the cell
// chain or waits in the holding stage.
// in_stall is high from acceptance until the result has moved to the output register.
// If the receiver stalls, the result waits in the output register and a finished
// following result waits in a holding stage until the output register frees up.
// Reset (synchronous, rst_n low) frees every cell, sets rows_in_use to 16 and empties
// the chain and the output; there is no clearing pass.
`default_nettype none
module slot_grid_first_fit_allocator_unit #(
  parameter int ROWS  = sgff_pkg::ROWS_DEF,
  parameter int SLOTS = sgff_pkg::SLOTS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  sgff_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output sgff_pkg::out_item_t   out_data,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [2:0]            paddr,
  input  wire  [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import sgff_pkg::*;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  state_t      state_r, state_nxt;
  in_item_t    req_r, req_nxt;
  chain_cmd_t  launch_r, launch_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [3:0]  placed_r, placed_nxt;
  logic [ROW_W-1:0] sel_row_r, sel_row_nxt;
  out_item_t   hold_r, hold_nxt;
  out_item_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  rows_r;

  chain_cmd_t        chain_w [SLOTS+1];
  logic [ROWS-1:0]   free_w  [SLOTS];
  logic [ROWS-1:0]   active;
  logic [ROWS-1:0]   full_free;
  logic              frag_ok;
  logic              found;
  logic [ROW_W-1:0]  low_row;
  int                nrows;
  out_item_t         result;
  logic              out_free;
  logic              in_xfer;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_IN_USE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ROWS_IN_USE)) begin
      rows_r <= pwdata[4:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_ROWS_IN_USE) begin
      prdata = {27'd0, rows_r};
    end
  end

  // searched rows, clamped to 1..ROWS
  always_comb begin
    nrows = int'(rows_r);
    if (nrows < 1) nrows = 1;
    if (nrows > ROWS) nrows = ROWS;
    for (int r = 0; r < ROWS; r++) begin
      active[r] = (r < nrows);
    end
  end

  // occupancy check over the window of the held request
  always_comb begin
    full_free = active;
    frag_ok   = 1'b1;
    for (int c = 0; c < SLOTS; c++) begin
      if ((int'(req_r.first_slot) <= c) && (c < int'(req_r.end_slot))) begin
        full_free = full_free & free_w[c];
        if ((free_w[c] & active) == '0) begin
          frag_ok = 1'b0;
        end
      end
    end
    found   = (full_free != '0);
    low_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (full_free[r]) begin
        low_row = ROW_W'(r);
      end
    end
  end

  // cell chain
  assign chain_w[0] = launch_r;

  for (genvar c = 0; c < SLOTS; c++) begin : g_cell
    sgff_cell #(
      .ROWS (ROWS),
      .COL  (c)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd_i     (chain_w[c]),
      .active_i  (active),
      .sel_row_i (sel_row_r),
      .cmd_o     (chain_w[c+1]),
      .free_o    (free_w[c])
    );
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    launch_nxt    = launch_r;
    launch_nxt.valid = 1'b0;
    status_nxt    = status_r;
    placed_nxt    = placed_r;
    sel_row_nxt   = sel_row_r;
    hold_nxt      = hold_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    result.status     = status_r;
    result.placed_row = placed_r;
    result.cell_owner = chain_w[SLOTS].cell_owner;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          req_nxt   = in_data;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        launch_nxt.valid      = 1'b1;
        launch_nxt.op         = OP_NONE;
        launch_nxt.first_slot = req_r.first_slot;
        launch_nxt.end_slot   = req_r.end_slot;
        launch_nxt.owner_tag  = req_r.owner_tag;
        launch_nxt.read_row   = req_r.read_row;
        launch_nxt.read_slot  = req_r.read_slot;
        launch_nxt.cell_owner = 8'd0;
        status_nxt  = ST_REJECT;
        placed_nxt  = 4'd0;
        sel_row_nxt = low_row;
        if (req_r.mode == MODE_READ) begin
          status_nxt    = ST_READ;
          launch_nxt.op = OP_READ;
        end else if (req_r.first_slot >= req_r.end_slot) begin
          // empty window succeeds in row 0 with no writes
          status_nxt = ST_SINGLE;
        end else if ((int'(req_r.end_slot) <= SLOTS) && (req_r.owner_tag != 8'd0)) begin
          if (found) begin
            status_nxt    = ST_SINGLE;
            placed_nxt    = 4'(low_row);
            launch_nxt.op = OP_SINGLE;
          end else if (frag_ok) begin
            status_nxt    = ST_FRAG;
            launch_nxt.op = OP_FRAG;
          end
        end
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (chain_w[SLOTS].valid) begin
          if (out_free) begin
            out_nxt       = result;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            hold_nxt  = result;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_nxt       = hold_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    status_r  <= status_nxt;
    placed_r  <= placed_nxt;
    sel_row_r <= sel_row_nxt;
    hold_r    <= hold_nxt;
    out_r     <= out_nxt;
  end

endmodule
`default_nettype wire
